>>> sv/hsl_to_rgb_converter_unit_defines.svh
// Assertion macros shared by the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define HSLRGB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsl_to_rgb_converter_unit: implication check failed");
`define HSLRGB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsl_to_rgb_converter_unit: next-cycle check failed");
`else
`define HSLRGB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HSLRGB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/hslrgb_pkg.sv
// Constants and the hue ramp weight function for the HSL to RGB converter.
`default_nettype none

package hslrgb_pkg;

	localparam int HUE_W      = 15;
	localparam int HUE_EXT_W  = 17;
	localparam int HUE_POS_W  = 13;
	localparam int WEIGHT_W   = 10;
	localparam int CHAN_W     = 8;

	localparam int TURN            = 5760;
	localparam int THIRD_TURN      = 1920;
	localparam int SIXTH_TURN      = 960;
	localparam int HALF_TURN       = 2880;
	localparam int TWO_THIRDS_TURN = 3840;

	// Weight k of the ramp so that the channel level is p + (q - p) * k / 960.
	// A position of exactly one turn falls in the last segment and gives p.
	function automatic logic [WEIGHT_W-1:0] ramp_weight(input logic [HUE_POS_W-1:0] t);
		logic [WEIGHT_W-1:0] k;
		k = '0;
		if (t < HUE_POS_W'(SIXTH_TURN)) begin
			k = t[WEIGHT_W-1:0];
		end else if (t < HUE_POS_W'(HALF_TURN)) begin
			k = WEIGHT_W'(SIXTH_TURN);
		end else if (t < HUE_POS_W'(TWO_THIRDS_TURN)) begin
			k = WEIGHT_W'(HUE_POS_W'(TWO_THIRDS_TURN) - t);
		end else begin
			k = '0;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

>>> sv/hslrgb_if.sv
// Valid/ready channel interfaces for HSL input words and RGB output words.
`default_nettype none

interface hslrgb_in_if #(parameter int LEVEL_FRAC_BITS = 10);
	logic                                valid;
	logic                                ready;
	logic signed [hslrgb_pkg::HUE_W-1:0] hue;
	logic [LEVEL_FRAC_BITS:0]            saturation;
	logic [LEVEL_FRAC_BITS:0]            lightness;
	logic [LEVEL_FRAC_BITS:0]            alpha_in;

	modport source (output valid, output hue, output saturation, output lightness,
		output alpha_in, input ready);
	modport sink (input valid, input hue, input saturation, input lightness,
		input alpha_in, output ready);
endinterface

interface hslrgb_out_if #(parameter int LEVEL_FRAC_BITS = 10);
	logic                              valid;
	logic                              ready;
	logic [hslrgb_pkg::CHAN_W-1:0]     red;
	logic [hslrgb_pkg::CHAN_W-1:0]     green;
	logic [hslrgb_pkg::CHAN_W-1:0]     blue;
	logic [LEVEL_FRAC_BITS:0]          alpha_out;

	modport source (output valid, output red, output green, output blue,
		output alpha_out, input ready);
	modport sink (input valid, input red, input green, input blue,
		input alpha_out, output ready);
endinterface

`default_nettype wire

>>> sv/hsl_to_rgb_converter_unit.sv
// HSL to RGB converter: a five-stage pipeline taking one HSLA color per word.
`default_nettype none
`include "hsl_to_rgb_converter_unit_defines.svh"

// Converts one HSLA word per clock, unless the output holds the pipe full, into
// 8-bit RGB plus clamped alpha. Each word passes five register stages: hue wrap
// and level clamp, the lightness times saturation product and ramp weights, q
// and p, the three ramp products, and the scaled and truncated channels in the
// output register. Each stage advances whenever the stage after it is empty
// or moving, so an empty stage anywhere in the pipe lets the input keep
// accepting while a finished word waits at the output. LEVEL_FRAC_BITS sets the
// level format (1.0 = 2^LEVEL_FRAC_BITS) in the range 8 to 16.
module hsl_to_rgb_converter_unit #(
	parameter int LEVEL_FRAC_BITS = 10
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hslrgb_in_if.sink     pixel_in,
	hslrgb_out_if.source  pixel_out
);

	localparam int F   = LEVEL_FRAC_BITS;
	localparam int LW  = F + 1;
	localparam int QW  = 2 * F + 1;
	localparam int WW  = QW + 2;
	localparam int PW  = QW + hslrgb_pkg::WEIGHT_W;
	localparam int SH  = 2 * F + 6;
	localparam int XW  = 2 * F + 15;
	localparam int TW  = XW - SH;
	localparam int HW  = hslrgb_pkg::HUE_EXT_W;
	localparam int PSW = hslrgb_pkg::HUE_POS_W;
	localparam int KW  = hslrgb_pkg::WEIGHT_W;
	localparam int CW  = hslrgb_pkg::CHAN_W;

	localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {F{1'b0}}};
	localparam logic [QW:0]   LEVEL_ONE_SQ = {2'b01, {(2 * F){1'b0}}};
	localparam logic signed [HW-1:0] TURN_S = HW'(hslrgb_pkg::TURN);

	// Stage enables: a stage loads when it is empty or its content moves on.
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic pipe_full;

	assign en_s5 = !v_s5 || pixel_out.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pixel_in.ready = en_s1;
	assign pipe_full = v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !pixel_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pixel_in.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: wrap the hue into one turn and clamp the levels.
	logic signed [HW-1:0] hue_ext;
	logic signed [HW-1:0] hue_cand;
	logic [PSW-1:0]       hue_wrap;
	logic [PSW-1:0]       hue_s1;
	logic [LW-1:0]        sat_s1, lit_s1, alpha_s1;

	assign hue_ext = {{(HW - hslrgb_pkg::HUE_W){pixel_in.hue[hslrgb_pkg::HUE_W-1]}},
		pixel_in.hue};

	// The input spans a little under three turns each way, so exactly one of
	// these shifted copies lands inside the turn.
	always_comb begin
		hue_wrap = '0;
		hue_cand = '0;
		for (int m = -2; m <= 3; m++) begin
			hue_cand = hue_ext + signed'(HW'(m * hslrgb_pkg::TURN));
			if (hue_cand >= 0 && hue_cand < TURN_S) begin
				hue_wrap = hue_cand[PSW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hue_s1   <= hue_wrap;
			sat_s1   <= (pixel_in.saturation > LEVEL_ONE) ? LEVEL_ONE : pixel_in.saturation;
			lit_s1   <= (pixel_in.lightness > LEVEL_ONE) ? LEVEL_ONE : pixel_in.lightness;
			alpha_s1 <= (pixel_in.alpha_in > LEVEL_ONE) ? LEVEL_ONE : pixel_in.alpha_in;
		end
	end

	// Stage 2: lightness times saturation and the three ramp weights.
	logic [2*LW-1:0] ls_full;
	logic [PSW-1:0]  t_red, t_blue;
	logic [QW-1:0]   ls_s2;
	logic [LW-1:0]   sat_s2, lit_s2, alpha_s2;
	logic            low_s2;
	logic [KW-1:0]   k_r_s2, k_g_s2, k_b_s2;

	assign ls_full = lit_s1 * sat_s1;

	always_comb begin
		t_red = hue_s1 + PSW'(hslrgb_pkg::THIRD_TURN);
		if (t_red > PSW'(hslrgb_pkg::TURN)) begin
			t_red = t_red - PSW'(hslrgb_pkg::TURN);
		end
		if (hue_s1 < PSW'(hslrgb_pkg::THIRD_TURN)) begin
			t_blue = hue_s1 + PSW'(hslrgb_pkg::TWO_THIRDS_TURN);
		end else begin
			t_blue = hue_s1 - PSW'(hslrgb_pkg::THIRD_TURN);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ls_s2    <= ls_full[QW-1:0];
			sat_s2   <= sat_s1;
			lit_s2   <= lit_s1;
			low_s2   <= (lit_s1[LW-1:LW-2] == 2'b00);
			alpha_s2 <= alpha_s1;
			k_r_s2   <= hslrgb_pkg::ramp_weight(t_red);
			k_g_s2   <= hslrgb_pkg::ramp_weight(hue_s1);
			k_b_s2   <= hslrgb_pkg::ramp_weight(t_blue);
		end
	end

	// Stage 3: q and p in Q(2F). The sums wrap in WW bits but the results are
	// known to lie in 0..1.0, so the low QW bits are exact.
	logic [WW-1:0] lo_w, so_w, ls_w, q2_w, p2_w, d_w;
	logic [QW-1:0] p2_s3, d_s3;
	logic [LW-1:0] alpha_s3;
	logic [KW-1:0] k_r_s3, k_g_s3, k_b_s3;
	logic [QW:0]   lvl_sum_s3;

	always_comb begin
		lo_w = {2'b00, lit_s2, {F{1'b0}}};
		so_w = {2'b00, sat_s2, {F{1'b0}}};
		ls_w = {2'b00, ls_s2};
		if (low_s2) begin
			q2_w = lo_w + ls_w;
			p2_w = lo_w - ls_w;
		end else begin
			q2_w = lo_w + so_w - ls_w;
			p2_w = lo_w - so_w + ls_w;
		end
		d_w = q2_w - p2_w;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			p2_s3    <= p2_w[QW-1:0];
			d_s3     <= d_w[QW-1:0];
			alpha_s3 <= alpha_s2;
			k_r_s3   <= k_r_s2;
			k_g_s3   <= k_g_s2;
			k_b_s3   <= k_b_s2;
		end
	end

	assign lvl_sum_s3 = {1'b0, p2_s3} + {1'b0, d_s3};

	// Stage 4: the ramp products, and p scaled by 960 * 17 = 16320.
	logic [PW-1:0] prod_r, prod_g, prod_b;
	logic [XW-1:0] base_w;
	logic [PW-1:0] prod_r_s4, prod_g_s4, prod_b_s4;
	logic [XW-1:0] base_s4;
	logic [LW-1:0] alpha_s4;

	assign prod_r = d_s3 * k_r_s3;
	assign prod_g = d_s3 * k_g_s3;
	assign prod_b = d_s3 * k_b_s3;
	assign base_w = (XW'(p2_s3) << 14) - (XW'(p2_s3) << 6);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			prod_r_s4 <= prod_r;
			prod_g_s4 <= prod_g;
			prod_b_s4 <= prod_b;
			base_s4   <= base_w;
			alpha_s4  <= alpha_s3;
		end
	end

	// Stage 5: 255 / 960 equals 17 / 64, so a channel is
	// floor((p * 16320 + (q - p) * k * 17) / 2^(2F+6)), limited to 255.
	function automatic logic [CW-1:0] to_channel(input logic [XW-1:0] base,
		input logic [PW-1:0] prod);
		logic [XW-1:0] x;
		logic [TW-1:0] top;
		x   = base + (XW'(prod) << 4) + XW'(prod);
		top = x[XW-1:SH];
		return (top > TW'(255)) ? {CW{1'b1}} : top[CW-1:0];
	endfunction

	logic [CW-1:0] red_s5, green_s5, blue_s5;
	logic [LW-1:0] alpha_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			red_s5   <= to_channel(base_s4, prod_r_s4);
			green_s5 <= to_channel(base_s4, prod_g_s4);
			blue_s5  <= to_channel(base_s4, prod_b_s4);
			alpha_s5 <= alpha_s4;
		end
	end

	assign pixel_out.valid     = v_s5;
	assign pixel_out.red       = red_s5;
	assign pixel_out.green     = green_s5;
	assign pixel_out.blue      = blue_s5;
	assign pixel_out.alpha_out = alpha_s5;

	// The input only stalls when every stage is full and the output is held.
	`HSLRGB_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, !pixel_in.ready, pipe_full)
	// A word in the first stage that cannot move must still be there next cycle.
	`HSLRGB_ASSERT_NXT(a_s1_word_kept, clk, arst_n, v_s1 && !en_s2, v_s1)
	// q = p + (q - p) never exceeds 1.0 squared.
	`HSLRGB_ASSERT_IMP(a_q_in_range, clk, arst_n, v_s3, lvl_sum_s3 <= LEVEL_ONE_SQ)

endmodule

`default_nettype wire
